[src/u16u8_pkg.sv]
// ----------------------------------------------------------------------------
// u16u8_pkg - shared types, constants and the UTF-8 encoder
// Job descriptor passed from the front end to the byte serialiser, result
// byte type, surrogate constants and the code point encoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned MAX_BYTES   = 7;   // FFFD + BMP char + NUL

    localparam logic [15:0] CAP_RESET   = 16'd64;
    localparam logic [15:0] SURR_MASK   = 16'hFC00;
    localparam logic [15:0] HIGH_SURR   = 16'hD800;
    localparam logic [15:0] LOW_SURR    = 16'hDC00;
    localparam logic [20:0] REPL_CP     = 21'h00FFFD;
    localparam logic [20:0] SUPP_BASE   = 21'h010000;
    localparam logic [20:0] TWO_BYTE_LO = 21'h000080;
    localparam logic [20:0] THR_BYTE_LO = 21'h000800;

    // Encoded character: bytes[0] goes out first
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      len;
    } enc_t;

    // One request's worth of output bytes
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [2:0]                n_bytes;  // 1..7
        logic                      nul;      // last byte is the terminator
        logic                      trunc;    // terminator after a stop
    } job_t;

    // One result byte with its flags
    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_item;
        logic       end_of_string;
        logic       truncated;
    } res_t;

    // cp must already be a valid scalar value
    function automatic enc_t encode(input logic [20:0] cp);
        enc_t e;
        e.bytes = '0;
        if (cp >= SUPP_BASE)
        begin
            e.bytes[0] = {5'b11110, cp[20:18]};
            e.bytes[1] = {2'b10, cp[17:12]};
            e.bytes[2] = {2'b10, cp[11:6]};
            e.bytes[3] = {2'b10, cp[5:0]};
            e.len      = 3'd4;
        end
        else if (cp >= THR_BYTE_LO)
        begin
            e.bytes[0] = {4'b1110, cp[15:12]};
            e.bytes[1] = {2'b10, cp[11:6]};
            e.bytes[2] = {2'b10, cp[5:0]};
            e.len      = 3'd3;
        end
        else if (cp >= TWO_BYTE_LO)
        begin
            e.bytes[0] = {3'b110, cp[10:6]};
            e.bytes[1] = {2'b10, cp[5:0]};
            e.len      = 3'd2;
        end
        else
        begin
            e.bytes[0] = {1'b0, cp[6:0]};
            e.len      = 3'd1;
        end
        return e;
    endfunction

endpackage

[src/u16u8_front.sv]
// ----------------------------------------------------------------------------
// u16u8_front - code unit classifier
// Pairs surrogates, applies the output budget and builds one job per request
// that produces any bytes.
// ----------------------------------------------------------------------------
module u16u8_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [15:0]       out_capacity,
    input  logic              accept,
    input  logic [15:0]       code_unit,
    input  logic              last_unit,
    output logic              q_push,
    output u16u8_pkg::job_t   q_job
);

    logic [9:0]  held_high_reg, held_high_next;
    logic        held_valid_reg, held_valid_next;
    logic [15:0] room_left_reg, room_left_next;
    logic        stopped_reg, stopped_next;
    logic        fresh_reg, fresh_next;

    logic        is_high, is_low;
    logic [15:0] room_eff, room_a, room_b;
    logic        a_present, b_present, hold_new;
    logic [20:0] a_cp, b_cp;
    u16u8_pkg::enc_t enc_a, enc_b;
    logic        a_fit, b_fit, stop_now, active;
    logic [2:0]  len_a_e, len_b_e, len_ab, off;

    assign is_high = (code_unit & u16u8_pkg::SURR_MASK) == u16u8_pkg::HIGH_SURR;
    assign is_low  = (code_unit & u16u8_pkg::SURR_MASK) == u16u8_pkg::LOW_SURR;

    always_comb
    begin
        if (fresh_reg)
            room_eff = (out_capacity == 16'd0) ? 16'd1 : out_capacity;
        else
            room_eff = room_left_reg;
    end

    // Up to two characters: a flushed/paired one, then the current unit
    always_comb
    begin
        if (held_valid_reg)
        begin
            a_present = 1'b1;
            a_cp      = is_low ? (u16u8_pkg::SUPP_BASE
                                  + {1'b0, held_high_reg, code_unit[9:0]})
                               : u16u8_pkg::REPL_CP;
            b_present = !is_low && !is_high;
            hold_new  = !is_low && is_high;
        end
        else
        begin
            a_present = !is_high;
            a_cp      = is_low ? u16u8_pkg::REPL_CP : {5'd0, code_unit};
            b_present = 1'b0;
            hold_new  = is_high;
        end
        b_cp = {5'd0, code_unit};
    end

    assign enc_a = u16u8_pkg::encode(a_cp);
    assign enc_b = u16u8_pkg::encode(b_cp);

    assign active   = !stopped_reg;
    assign room_a   = room_eff - {13'd0, enc_a.len};
    assign room_b   = room_a - {13'd0, enc_b.len};
    assign a_fit    = a_present && ({13'd0, enc_a.len} < room_eff);
    assign b_fit    = b_present && a_fit && ({13'd0, enc_b.len} < room_a);
    assign stop_now = active && ((a_present && !a_fit) || (b_present && a_fit && !b_fit));

    assign len_a_e = (active && a_fit) ? enc_a.len : 3'd0;
    assign len_b_e = (active && b_fit) ? enc_b.len : 3'd0;
    assign len_ab  = len_a_e + len_b_e;

    always_comb
    begin
        off = 3'd0;
        for (int i = 0; i < u16u8_pkg::MAX_BYTES; i++)
        begin
            off = 3'(i) - len_a_e;
            if (3'(i) < len_a_e)
                q_job.bytes[i] = enc_a.bytes[i[1:0]];
            else if (3'(i) < len_ab)
                q_job.bytes[i] = enc_b.bytes[off[1:0]];
            else
                q_job.bytes[i] = 8'h00;
        end
        q_job.n_bytes = len_ab + {2'd0, last_unit};
        q_job.nul     = last_unit;
        q_job.trunc   = last_unit && (stopped_reg || stop_now);
    end

    assign q_push = accept && (q_job.n_bytes != 3'd0);

    always_comb
    begin
        held_high_next  = held_high_reg;
        held_valid_next = held_valid_reg;
        room_left_next  = room_left_reg;
        stopped_next    = stopped_reg;
        fresh_next      = fresh_reg;
        if (accept)
        begin
            fresh_next     = 1'b0;
            room_left_next = room_eff;
            if (active)
            begin
                held_valid_next = hold_new && (!held_valid_reg || a_fit);
                if (hold_new)
                    held_high_next = code_unit[9:0];
                if (b_fit)
                    room_left_next = room_b;
                else if (a_fit)
                    room_left_next = room_a;
                stopped_next = stop_now;
            end
            if (last_unit)
            begin
                held_valid_next = 1'b0;
                stopped_next    = 1'b0;
                fresh_next      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            stopped_reg    <= 1'b0;
            fresh_reg      <= 1'b1;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            stopped_reg    <= stopped_next;
            fresh_reg      <= fresh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_high_reg <= held_high_next;
        room_left_reg <= room_left_next;
    end

endmodule

[src/u16u8_queue.sv]
// ----------------------------------------------------------------------------
// u16u8_queue - job queue
// Small register queue decoupling the classifier from the serialiser.
// ----------------------------------------------------------------------------
module u16u8_queue
#(
    parameter int unsigned DEPTH = u16u8_pkg::QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  u16u8_pkg::job_t   wr_job,
    input  logic              pop,
    output u16u8_pkg::job_t   rd_job,
    output logic              full,
    output logic              empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    u16u8_pkg::job_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = count_reg == CNT_W'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_job  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wr_job;
    end

endmodule

[src/u16u8_back.sv]
// ----------------------------------------------------------------------------
// u16u8_back - byte serialiser
// Walks the head job one byte per cycle, while the result stage is free or popped, into a registered result stage.
// ----------------------------------------------------------------------------
module u16u8_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  u16u8_pkg::job_t   q_job,
    output logic              q_pop,
    input  logic              pop,
    output logic              empty,
    output u16u8_pkg::res_t   res
);

    logic            out_valid_reg, out_valid_next;
    u16u8_pkg::res_t res_reg, res_next;
    logic [2:0]      idx_reg, idx_next;
    logic            load, last_byte;

    assign load      = !q_empty && (!out_valid_reg || pop);
    assign last_byte = idx_reg == (q_job.n_bytes - 3'd1);
    assign q_pop     = load && last_byte;
    assign empty     = !out_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        res_next       = res_reg;
        if (pop && out_valid_reg)
            out_valid_next = 1'b0;
        if (load)
        begin
            out_valid_next         = 1'b1;
            res_next.out_byte      = q_job.bytes[idx_reg];
            res_next.end_of_item   = last_byte;
            res_next.end_of_string = last_byte && q_job.nul;
            res_next.truncated     = last_byte && q_job.trunc;
            idx_next               = last_byte ? 3'd0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

[src/utf16_to_utf8_transcoder.sv]
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder - streaming UTF-16 to UTF-8 converter
// Top level: configuration register, classifier, job queue and serialiser.
// ----------------------------------------------------------------------------
// Usage
//   Input side behaves as a queue: drive code_unit/last_unit with push; a
//   request is taken on a clock edge with push high and full low. Result side
//   is a queue too: while empty is low the oldest byte sits on out_byte with
//   its flags, and pop takes it.
//   Each request yields 0..7 bytes; end_of_item marks the last byte of a
//   request, end_of_string and truncated ride on the terminating NUL.
//   cfg_wr_en/cfg_wr_data write out_capacity (budget incl. NUL); the value is
//   sampled at the first unit of each string. Write only when idle.
// Timing
//   The classifier handles a request in the accepting cycle and queues a job;
//   the job is written into the queue at the accepting edge and its first byte
//   is then registered in the result stage. The serialiser sends one byte per
//   cycle while pop keeps the result stage free. Requests are taken every
//   cycle while the job queue (QUEUE_DEPTH entries) has room.
// Reset and stall
//   Reset clears the queue, drops any held surrogate and loads a capacity of
//   64. While pop is low the result byte holds and the queue fills; full then
//   rises and input stalls without loss.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder
#(
    parameter int unsigned QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    // code unit queue
    input  logic        push,
    output logic        full,
    input  logic [15:0] code_unit,
    input  logic        last_unit,
    // byte queue
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        end_of_item,
    output logic        end_of_string,
    output logic        truncated
);

    logic [15:0]     out_capacity_reg;
    logic            accept;
    logic            q_push, q_pop, q_full, q_empty;
    u16u8_pkg::job_t wr_job, rd_job;
    u16u8_pkg::res_t res;

    // Capacity register, no read-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_capacity_reg <= u16u8_pkg::CAP_RESET;
        else if (cfg_wr_en)
            out_capacity_reg <= cfg_wr_data;
    end

    // Input stalls only on a full job queue
    assign full   = q_full;
    assign accept = push && !q_full;

    u16u8_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .out_capacity (out_capacity_reg),
        .accept       (accept),
        .code_unit    (code_unit),
        .last_unit    (last_unit),
        .q_push       (q_push),
        .q_job        (wr_job)
    );

    u16u8_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wr_job (wr_job),
        .pop    (q_pop),
        .rd_job (rd_job),
        .full   (q_full),
        .empty  (q_empty)
    );

    u16u8_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_job   (rd_job),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .res     (res)
    );

    assign out_byte      = res.out_byte;
    assign end_of_item   = res.end_of_item;
    assign end_of_string = res.end_of_string;
    assign truncated     = res.truncated;

    // The terminator always closes its request
    a_eos_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && end_of_string |-> end_of_item)
        else $error("terminator without end_of_item");

    // The terminator is a zero byte
    a_eos_is_nul: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && end_of_string |-> out_byte == 8'h00)
        else $error("terminator byte not zero");

    // truncated only rides on the terminator
    a_trunc_on_eos: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && truncated |-> end_of_string)
        else $error("truncated outside terminator");

    // A request taken into an empty pipeline: job queued at the accepting
    // edge, first byte registered at the next one
    a_first_byte: assert property (@(posedge clk) disable iff (!rst_n)
        accept && q_empty && empty && q_push |=> ##1 !empty)
        else $error("queued job produced no byte");

endmodule
